// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers. They compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== sv/shtok_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell argument tokenizer package
// Shared types, character codes and helpers of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package shtok_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
  localparam logic [7:0] CHAR_HASH       = 8'h23;
  localparam logic [7:0] ARG_SLOTS_RESET = 8'd16;

  typedef struct packed {
    logic       in_single_quote;
    logic       in_double_quote;
    logic       escape_pending;
    logic       inside_argument;
    logic       first_byte_pending;
    logic       comment_seen;
    logic       drop_to_line_end;
    logic [7:0] argument_count;
    logic [7:0] comment_index;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '0;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] arg_index;
    logic [7:0] arg_total;
    logic       last;
  } result_t;

  // Up to two results come from one input byte.
  typedef struct packed {
    result_t    first;
    result_t    second;
    logic [1:0] count;
  } step_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/shtok_char_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one command line byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface shtok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== sv/shtok_token_if.sv =====
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one tokenizer result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface shtok_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] arg_index;
  logic [7:0] arg_total;
  logic       last;

  modport source (output valid, output kind, output data_byte, output arg_index,
                  output arg_total, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input arg_index,
                  input arg_total, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/shtok_step.sv =====
// ----------------------------------------------------------------------------
// Tokenizer step
// Combinational next line state and up to two results for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module shtok_step (
  input  shtok_pkg::line_state_t state,
  input  logic [7:0]             char_code,
  input  logic [7:0]             arg_slots,
  output shtok_pkg::line_state_t state_next,
  output shtok_pkg::step_out_t   step
);

  logic [7:0]         lim_m1;
  logic [7:0]         idx;
  logic               keep;
  logic               blank;
  logic [1:0]         n;
  shtok_pkg::result_t r0;
  shtok_pkg::result_t r1;
  shtok_pkg::result_t extra;

  always_comb begin
    state_next = state;
    r0         = '0;
    r1         = '0;
    extra      = '0;
    n          = 2'd0;
    keep       = 1'b0;
    idx        = 8'd0;
    blank      = shtok_pkg::is_blank(char_code);
    // Register values below two behave as two.
    lim_m1     = (arg_slots < 8'd2) ? 8'd1 : arg_slots - 8'd1;

    if (char_code == shtok_pkg::CHAR_NUL) begin
      if (!state.drop_to_line_end) begin
        if (state.inside_argument && !state.comment_seen) begin
          r0.kind      = shtok_pkg::KIND_END;
          r0.arg_index = state.argument_count - 8'd1;
          n            = 2'd1;
        end
        extra.kind      = shtok_pkg::KIND_DONE;
        extra.arg_total = state.comment_seen ? state.comment_index
                                             : state.argument_count;
        if (n == 2'd0) begin
          r0 = extra;
        end else begin
          r1 = extra;
        end
        n = n + 2'd1;
      end
      state_next = shtok_pkg::LINE_CLEAR;
    end else if (!state.drop_to_line_end && !(!state.inside_argument && blank)) begin
      if (!state.inside_argument) begin
        state_next.inside_argument    = 1'b1;
        state_next.first_byte_pending = 1'b1;
        state_next.argument_count     = state.argument_count + 8'd1;
      end
      idx = state_next.argument_count - 8'd1;

      if (state.escape_pending) begin
        state_next.escape_pending = 1'b0;
        keep                      = 1'b1;
      end else if (char_code == shtok_pkg::CHAR_BACKSLASH) begin
        state_next.escape_pending = 1'b1;
      end else if (state.in_single_quote) begin
        if (char_code == shtok_pkg::CHAR_SQUOTE) begin
          state_next.in_single_quote = 1'b0;
        end else begin
          keep = 1'b1;
        end
      end else if (state.in_double_quote) begin
        if (char_code == shtok_pkg::CHAR_DQUOTE) begin
          state_next.in_double_quote = 1'b0;
        end else begin
          keep = 1'b1;
        end
      end else if (blank) begin
        state_next.inside_argument    = 1'b0;
        state_next.first_byte_pending = 1'b0;
        if (!state.comment_seen) begin
          r0.kind      = shtok_pkg::KIND_END;
          r0.arg_index = idx;
          n            = 2'd1;
        end
        if (state_next.argument_count >= lim_m1) begin
          extra.kind = shtok_pkg::KIND_ERROR;
          if (n == 2'd0) begin
            r0 = extra;
          end else begin
            r1 = extra;
          end
          n                           = n + 2'd1;
          state_next.drop_to_line_end = 1'b1;
        end
      end else if (char_code == shtok_pkg::CHAR_SQUOTE) begin
        state_next.in_single_quote = 1'b1;
      end else if (char_code == shtok_pkg::CHAR_DQUOTE) begin
        state_next.in_double_quote = 1'b1;
      end else begin
        keep = 1'b1;
      end

      if (keep) begin
        // The first kept byte of an argument decides whether a comment starts.
        if (state_next.first_byte_pending) begin
          state_next.first_byte_pending = 1'b0;
          if (char_code == shtok_pkg::CHAR_HASH && !state.comment_seen) begin
            state_next.comment_seen  = 1'b1;
            state_next.comment_index = idx;
          end
        end
        if (!state_next.comment_seen) begin
          r0.kind      = shtok_pkg::KIND_BYTE;
          r0.data_byte = char_code;
          r0.arg_index = idx;
          n            = 2'd1;
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end

    step.first  = r0;
    step.second = r1;
    step.count  = n;
  end

endmodule

`default_nettype wire

// ===== sv/shell_argument_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Shell argument tokenizer
// Splits a command line into arguments with quote, escape and comment rules.
//
//   channel    dir   payload                                       handshake
//   char_in    in    char_code                                     valid/ready
//   tok_out    out   kind, data_byte, arg_index, arg_total, last   valid/ready
//   cfg        in    cfg_wdata (arg_slots)                         cfg_we
//
// A byte is decoded in the cycle it is accepted; its results show on tok_out
// from the next cycle. A byte with one or no result allows a new byte every
// cycle while tok_out is ready; a byte with two results holds off the next
// byte while the two-entry result register drains. A new byte is taken while
// the final result of the previous one transfers. Reset clears line state,
// sets arg_slots to 16 and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shell_argument_tokenizer (
  input  logic                 clk,
  input  logic                 rst,
  shtok_char_if.sink           char_in,
  shtok_token_if.source        tok_out,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  shtok_pkg::line_state_t state;
  shtok_pkg::line_state_t state_next;
  shtok_pkg::step_out_t   step;
  shtok_pkg::result_t     slot_a;
  shtok_pkg::result_t     slot_b;
  logic [1:0]             count;
  logic [7:0]             arg_slots;
  logic                   in_fire;
  logic                   out_fire;

  shtok_step u_step (
    .state      (state),
    .char_code  (char_in.char_code),
    .arg_slots  (arg_slots),
    .state_next (state_next),
    .step       (step)
  );

  assign out_fire      = tok_out.valid & tok_out.ready;
  assign char_in.ready = (count == 2'd0) || (count == 2'd1 && tok_out.ready);
  assign in_fire       = char_in.valid & char_in.ready;

  assign tok_out.valid     = (count != 2'd0);
  assign tok_out.kind      = slot_a.kind;
  assign tok_out.data_byte = slot_a.data_byte;
  assign tok_out.arg_index = slot_a.arg_index;
  assign tok_out.arg_total = slot_a.arg_total;
  assign tok_out.last      = slot_a.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shtok_pkg::LINE_CLEAR;
      arg_slots <= shtok_pkg::ARG_SLOTS_RESET;
      count     <= 2'd0;
    end else begin
      if (cfg_we) begin
        arg_slots <= cfg_wdata;
      end
      if (in_fire) begin
        state <= state_next;
        count <= step.count;
      end else if (out_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  // Result slots: the second slot moves up when the first one transfers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_a <= step.first;
      slot_b <= step.second;
    end else if (out_fire) begin
      slot_a <= slot_b;
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3)
  `ASSERT_IMPLY(a_pair_head_not_last, clk, rst, count == 2'd2, !slot_a.last)
  `ASSERT_IMPLY(a_drop_closed, clk, rst, state.drop_to_line_end, !state.inside_argument)
  `ASSERT_IMPLY(a_comment_idx, clk, rst, state.comment_seen,
                state.comment_index < state.argument_count)
  `ASSERT_NEXT(a_pair_loaded, clk, rst, in_fire && step.count == 2'd2, count == 2'd2)

endmodule

`default_nettype wire
